// ===== rtl/dsu_pkg.sv =====
// Shared constants and the command/status types that join the DSU controller and datapath.
`default_nettype none

package dsu_pkg;

	localparam int NODE_W          = 10;
	localparam int DEF_MAX_NODES   = 1024;
	localparam int IN_TDATA_W      = 24;
	localparam int IN_TUSER_W      = 1;
	localparam int OUT_TDATA_W     = 16;

	// opcode values carried on s_axis_tuser
	localparam logic OP_FIND  = 1'b0;
	localparam logic OP_UNION = 1'b1;

	typedef struct packed {
		logic clr_wr;      // write -1 at the clear pointer and advance it
		logic accept;      // latch a request, start the find of node_a
		logic start_b;     // start the find of node_b
		logic walk_step;   // follow the parent link just read
		logic walk_end;    // record the root and its size for the current find
		logic cmp_start;   // begin path rewrite at the start node
		logic cmp_step;    // point the current entry at the root, follow its old link
		logic link_keep;   // write the summed size into the surviving root
		logic link_child;  // point the absorbed root at the surviving root
		logic load_out;    // load the result register
		logic find_b;      // level: the current find is the one of node_b
	} dsu_cmd_t;

	typedef struct packed {
		logic clr_last;    // clear pointer at the last entry
		logic in_range;    // request nodes lie inside the table
		logic is_union;    // latched opcode is a union
		logic is_root;     // entry just read holds a negated size
		logic at_start;    // root is the start node itself
		logic cmp_end;     // link just read points at the root
		logic same_root;   // both finds ended at one root
	} dsu_stat_t;

endpackage

`default_nettype wire

// ===== rtl/disjoint_set_union_engine_top.sv =====
// Top level of the disjoint-set union engine: controller and datapath.
//
//  channel  | direction | tdata (low bit up)                    | tuser
//  ---------+-----------+---------------------------------------+-------------
//  s_axis   | in        | node_a[9:0], node_b[19:10], zero pad  | opcode[0]
//  m_axis   | out       | root[9:0], merged[10], zero pad       | -
//
// A find follows L parent links in the table memory to its root, then rewrites C
// entries during path compression, one memory port access each. A union runs
// two finds, and when it merges adds two link writes on the single write port.
// After reset a clearing pass writes every table entry while s_axis_tready stays
// low. One request is in work at a time; a finished result waits in the output
// register while the next request is accepted, and finishing stalls only if
// that register is full.
`default_nettype none

module disjoint_set_union_engine_top #(
	parameter int MAX_NODES = dsu_pkg::DEF_MAX_NODES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [dsu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // node_a, node_b
	input  wire logic [dsu_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // opcode
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [dsu_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // root, merged
);
	import dsu_pkg::*;

	dsu_cmd_t  cmd;
	dsu_stat_t stat;

	dsu_controller u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	dsu_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== rtl/dsu_datapath.sv =====
// DSU datapath: link table memory, walk pointers, root and size registers, result register.
`default_nettype none

module dsu_datapath #(
	parameter int MAX_NODES = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [dsu_pkg::IN_TDATA_W-1:0] in_tdata,
	input  wire logic [dsu_pkg::IN_TUSER_W-1:0] in_tuser,
	input  wire dsu_pkg::dsu_cmd_t              cmd,
	output dsu_pkg::dsu_stat_t                  stat,
	output logic [dsu_pkg::OUT_TDATA_W-1:0]     out_tdata
);
	import dsu_pkg::*;

	localparam int IDX_W   = $clog2(MAX_NODES);
	localparam int ENTRY_W = IDX_W + 1;

	logic signed [ENTRY_W-1:0] mem [MAX_NODES];
	logic signed [ENTRY_W-1:0] rdata_q;

	logic              op_q;
	logic [NODE_W-1:0] a_q;
	logic [NODE_W-1:0] b_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  start_q;
	logic [IDX_W-1:0]  walk_q;
	logic [IDX_W-1:0]  root_a_q;
	logic [IDX_W-1:0]  root_b_q;
	logic signed [ENTRY_W-1:0] size_a_q;
	logic signed [ENTRY_W-1:0] size_b_q;
	logic [IDX_W-1:0]  clr_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;

	logic [NODE_W-1:0] in_a;
	logic [NODE_W-1:0] in_b;
	logic [31:0]       in_a_ext;
	logic [31:0]       a_ext;
	logic [31:0]       b_ext;
	logic [IDX_W-1:0]  in_a_idx;
	logic [IDX_W-1:0]  b_idx;
	logic [IDX_W-1:0]  link_idx;
	logic [IDX_W-1:0]  root_cur;
	logic [IDX_W-1:0]  keep_idx;
	logic [IDX_W-1:0]  child_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic signed [ENTRY_W-1:0] wr_data;
	logic              a_ok;
	logic              b_ok;
	logic [IDX_W-1:0]  res_idx;
	logic [31:0]       res_ext;
	logic [NODE_W-1:0] res_root;
	logic              res_merged;

	assign in_a     = in_tdata[NODE_W-1:0];
	assign in_b     = in_tdata[2*NODE_W-1:NODE_W];
	assign in_a_ext = 32'(in_a);
	assign in_a_idx = in_a_ext[IDX_W-1:0];
	assign a_ext    = 32'(a_q);
	assign b_ext    = 32'(b_q);
	assign b_idx    = b_ext[IDX_W-1:0];
	assign link_idx = rdata_q[IDX_W-1:0];
	assign root_cur = cmd.find_b ? root_b_q : root_a_q;

	assign a_ok = a_ext < 32'(MAX_NODES);
	assign b_ok = b_ext < 32'(MAX_NODES);

	// more negative size means the larger set; a tie keeps node_b's root
	always_comb begin
		if (size_a_q < size_b_q) begin
			keep_idx  = root_a_q;
			child_idx = root_b_q;
		end else begin
			keep_idx  = root_b_q;
			child_idx = root_a_q;
		end
	end

	always_comb begin
		if (cmd.accept) begin
			rd_addr = in_a_idx;
		end else if (cmd.start_b) begin
			rd_addr = b_idx;
		end else if (cmd.cmp_start) begin
			rd_addr = start_q;
		end else if (cmd.walk_step || cmd.cmp_step) begin
			rd_addr = link_idx;
		end else begin
			rd_addr = cur_q;
		end
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = walk_q;
		wr_data = $signed({1'b0, root_cur});
		if (cmd.clr_wr) begin
			wr_addr = clr_q;
			wr_data = '1;
		end else if (cmd.cmp_step) begin
			wr_addr = walk_q;
			wr_data = $signed({1'b0, root_cur});
		end else if (cmd.link_keep) begin
			wr_addr = keep_idx;
			wr_data = size_a_q + size_b_q;
		end else if (cmd.link_child) begin
			wr_addr = child_idx;
			wr_data = $signed({1'b0, keep_idx});
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_tuser[0];
			a_q     <= in_a;
			b_q     <= in_b;
			cur_q   <= in_a_idx;
			start_q <= in_a_idx;
		end else if (cmd.start_b) begin
			cur_q   <= b_idx;
			start_q <= b_idx;
		end else if (cmd.walk_step) begin
			cur_q <= link_idx;
		end
		if (cmd.cmp_start) begin
			walk_q <= start_q;
		end else if (cmd.cmp_step) begin
			walk_q <= link_idx;
		end
		if (cmd.walk_end) begin
			if (cmd.find_b) begin
				root_b_q <= cur_q;
				size_b_q <= rdata_q;
			end else begin
				root_a_q <= cur_q;
				size_a_q <= rdata_q;
			end
		end
		if (cmd.load_out) begin
			out_tdata_q <= OUT_TDATA_W'({res_merged, res_root});
		end
	end

	always_comb begin
		res_idx    = root_a_q;
		res_merged = 1'b0;
		if (stat.in_range && op_q == OP_UNION && root_a_q != root_b_q) begin
			res_idx    = keep_idx;
			res_merged = 1'b1;
		end
	end
	assign res_ext  = 32'(res_idx);
	assign res_root = stat.in_range ? res_ext[NODE_W-1:0] : a_q;

	assign stat.clr_last  = clr_q == IDX_W'(MAX_NODES - 1);
	assign stat.in_range  = a_ok && (op_q == OP_FIND || b_ok);
	assign stat.is_union  = op_q == OP_UNION;
	assign stat.is_root   = rdata_q[ENTRY_W-1];
	assign stat.at_start  = cur_q == start_q;
	assign stat.cmp_end   = link_idx == root_cur;
	assign stat.same_root = root_a_q == root_b_q;

	assign out_tdata = out_tdata_q;

	a_cmp_follows_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_step |-> !rdata_q[ENTRY_W-1])
		else $error("path rewrite stepped onto a root entry");

	a_link_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_keep |-> !stat.same_root)
		else $error("link issued for a single root");

endmodule

`default_nettype wire

// ===== rtl/dsu_controller.sv =====
// DSU controller: sequences clearing, finds, path rewrite, linking and result handoff.
`default_nettype none

module dsu_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	input  wire dsu_pkg::dsu_stat_t stat,
	output dsu_pkg::dsu_cmd_t       cmd
);
	import dsu_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_CMP,
		ST_AFTER,
		ST_LINK,
		ST_LINK2,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   find_b_q;
	logic   out_valid_q;
	logic   can_load;

	assign can_load      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.find_b = find_b_q;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE:  cmd.accept = s_axis_tvalid;
			ST_WALK: begin
				if (stat.in_range) begin
					if (!stat.is_root) begin
						cmd.walk_step = 1'b1;
					end else begin
						cmd.walk_end  = 1'b1;
						cmd.cmp_start = !stat.at_start;
					end
				end
			end
			ST_CMP:   cmd.cmp_step = 1'b1;
			ST_AFTER: cmd.start_b = stat.is_union && !find_b_q;
			ST_LINK:  cmd.link_keep = 1'b1;
			ST_LINK2: cmd.link_child = 1'b1;
			ST_FINISH: cmd.load_out = can_load;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			find_b_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!stat.in_range) begin
						state_q <= ST_FINISH;
					end else if (stat.is_root) begin
						state_q <= stat.at_start ? ST_AFTER : ST_CMP;
					end
				end
				ST_CMP: begin
					if (stat.cmp_end) begin
						state_q <= ST_AFTER;
					end
				end
				ST_AFTER: begin
					if (stat.is_union && !find_b_q) begin
						find_b_q <= 1'b1;
						state_q  <= ST_WALK;
					end else if (stat.is_union && !stat.same_root) begin
						state_q <= ST_LINK;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_LINK:  state_q <= ST_LINK2;
				ST_LINK2: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (can_load) begin
						find_b_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_axis_tready)
		else $error("request accepted during table clear");

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> state_q == ST_WALK && !find_b_q)
		else $error("accepted request did not start the first find");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_axis_tvalid)
		else $error("loaded result not presented");

	a_link_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_keep |=> cmd.link_child)
		else $error("size update not followed by child link");

endmodule

`default_nettype wire
